// File: rtl/cmv_pkg.sv
// Shared constants, codes and helper functions for the cylinder mesh vertex generator.
`timescale 1ns / 1ps

package cmv_pkg;

  // Request kinds.
  localparam logic [1:0] REQ_TOP    = 2'd0;
  localparam logic [1:0] REQ_BOTTOM = 2'd1;
  localparam logic [1:0] REQ_SIDE   = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDES   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENTS = 4'd3;

  // Divider geometry: quotient bits and divisor bits.
  localparam int DIV_QW = 31;
  localparam int DIV_DW = 11;

  // CORDIC geometry, Q2.30 values carried in CW bits.
  localparam int CORDIC_ITER = 16;
  localparam int CW = 34;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  function automatic logic signed [CW-1:0] atan_q30(input int unsigned i);
    logic signed [CW-1:0] a;
    case (i)
      0:  a = 34'sd843314856;
      1:  a = 34'sd497837829;
      2:  a = 34'sd263043836;
      3:  a = 34'sd133525158;
      4:  a = 34'sd67021686;
      5:  a = 34'sd33543515;
      6:  a = 34'sd16775850;
      7:  a = 34'sd8388437;
      8:  a = 34'sd4194282;
      9:  a = 34'sd2097149;
      10: a = 34'sd1048575;
      11: a = 34'sd524287;
      12: a = 34'sd262143;
      13: a = 34'sd131071;
      14: a = 34'sd65535;
      15: a = 34'sd32767;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/cylinder_mesh_vertex_generator.sv
// Top level of the cylinder mesh vertex generator: request intake, pipeline and vertex emitter.
`timescale 1ns / 1ps

// Usage
//   Request channel: drive in_req_type, in_side_index and in_segment_index with start high;
//   the item is taken at a clock edge where start is high and busy is low.
//   Result channel: each vertex shows on the out_ ports for one cycle with out_valid high;
//   out_last_vertex marks the final vertex of the item. The receiver cannot stall.
//   Config channel: cfg_valid with cfg_index and cfg_data; cfg_ready is always high.
//   Write registers only while no item is in flight.
// Timing
//   The first vertex of an item leaves once the item has passed the pipeline, the rest follow
//   on back-to-back cycles. The depth comes from the 31-stage divider and the 16-stage
//   CORDIC in series. After a cap or side item is taken, busy stays high long enough that
//   items enter no faster than their vertices leave: one vertex per cycle on the result port.
//   An item with an out-of-range index or the unused kind gives nothing and
//   does not raise busy.
// Reset
//   Synchronous, active low: clears all valid bits and the emitter and loads the default
//   radius 1.0, height 1.0, 16 sides and 1 segment.
module cylinder_mesh_vertex_generator #(
  parameter int MAX_DIVISIONS    = 1024,
  parameter int ANGLE_TABLE_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_req_type,
  input  logic [9:0]                     in_side_index,
  input  logic [9:0]                     in_segment_index,
  // result channel
  output logic                           out_valid,
  output logic signed [31:0]             out_pos_x,
  output logic signed [31:0]             out_pos_y,
  output logic signed [31:0]             out_pos_z,
  output logic signed [17:0]             out_norm_x,
  output logic signed [17:0]             out_norm_y,
  output logic signed [17:0]             out_norm_z,
  output logic [16:0]                    out_tex_u,
  output logic [16:0]                    out_tex_v,
  output logic                           out_last_vertex,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cmv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);

  localparam int B          = ANGLE_TABLE_BITS;
  localparam int RB         = B - 2;
  localparam int QW         = cmv_pkg::DIV_QW;
  localparam int DW         = cmv_pkg::DIV_DW;
  localparam int CW         = cmv_pkg::CW;
  localparam int NUM_W      = QW + DW;
  localparam int DIV_LAT    = QW + 1;
  localparam int CORDIC_LAT = cmv_pkg::CORDIC_ITER + 1;
  // Level of the last arithmetic register before the vertex hold register.
  localparam int P2_LVL     = DIV_LAT + 1 + CORDIC_LAT + 2;

  typedef struct packed {
    logic side;
    logic top;
  } flags_t;

  typedef struct packed {
    flags_t             fl;
    logic [1:0]         quad0;
    logic [1:0]         quad1;
    logic [16:0]        u_l;
    logic [16:0]        u_r;
    logic [16:0]        v_t;
    logic [16:0]        v_b;
    logic signed [31:0] y_a;
    logic signed [31:0] y_b;
  } pay_t;

  typedef struct packed {
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] s;
  } cs_t;

  typedef struct packed {
    flags_t             fl;
    logic signed [31:0] x_l;
    logic signed [31:0] z_l;
    logic signed [31:0] x_r;
    logic signed [31:0] z_r;
    logic signed [17:0] nx_l;
    logic signed [17:0] nz_l;
    logic signed [17:0] nx_r;
    logic signed [17:0] nz_r;
    logic signed [31:0] y_a;
    logic signed [31:0] y_b;
    logic [16:0]        tu_l;
    logic [16:0]        tu_r;
    logic [16:0]        tv_0;
    logic [16:0]        tv_1;
  } vset_t;

  function automatic cs_t quad_map(input logic [1:0] q, input logic neg,
                                   input logic signed [CW-1:0] x,
                                   input logic signed [CW-1:0] y);
    cs_t r;
    case (q)
      2'd0:    begin r.c = x;  r.s = y;  end
      2'd1:    begin r.c = -y; r.s = x;  end
      2'd2:    begin r.c = -x; r.s = -y; end
      default: begin r.c = y;  r.s = -x; end
    endcase
    if (neg) begin
      r.s = -r.s;
    end
    return r;
  endfunction

  function automatic logic signed [17:0] to_q16(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    logic signed [17:0]   r;
    t = (v + CW'(8192)) >>> 14;
    if (t > CW'(65536)) begin
      r = 18'sd65536;
    end else if (t < -CW'(65536)) begin
      r = -18'sd65536;
    end else begin
      r = t[17:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] rim_sat(input logic signed [CW+31:0] p);
    logic signed [CW+31:0] t;
    logic signed [31:0]    r;
    t = (p + (CW+32)'(64'sd536870912)) >>> 30;
    if (t > (CW+32)'(64'sd2147483647)) begin
      r = 32'sh7fffffff;
    end else if (t < -(CW+32)'(64'sd2147483648)) begin
      r = 32'sh80000000;
    end else begin
      r = t[31:0];
    end
    return r;
  endfunction

  function automatic logic [16:0] tex_of(input logic signed [17:0] q);
    logic signed [18:0] t;
    t = 19'(q) + 19'sd65536;
    return t[17:1];
  endfunction

  // ---------------------------------------------------------------- config
  logic [30:0] cyl_radius_r;
  logic [30:0] cyl_height_r;
  logic [10:0] side_count_r;
  logic [10:0] segment_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cyl_radius_r    <= 31'd65536;
      cyl_height_r    <= 31'd65536;
      side_count_r    <= 11'd16;
      segment_count_r <= 11'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cmv_pkg::CFG_RADIUS:   cyl_radius_r    <= cfg_data[30:0];
        cmv_pkg::CFG_HEIGHT:   cyl_height_r    <= cfg_data[30:0];
        cmv_pkg::CFG_SIDES:    side_count_r    <= cfg_data[10:0];
        cmv_pkg::CFG_SEGMENTS: segment_count_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Saturate the division counts to their legal range.
  logic [DW-1:0] n_eff;
  logic [DW-1:0] sg_eff;

  always_comb begin
    if (side_count_r < 11'd3) begin
      n_eff = 11'd3;
    end else if (int'(side_count_r) > MAX_DIVISIONS) begin
      n_eff = DW'(MAX_DIVISIONS);
    end else begin
      n_eff = side_count_r;
    end
    if (segment_count_r == 11'd0) begin
      sg_eff = 11'd1;
    end else if (int'(segment_count_r) > MAX_DIVISIONS) begin
      sg_eff = DW'(MAX_DIVISIONS);
    end else begin
      sg_eff = segment_count_r;
    end
  end

  // ---------------------------------------------------------------- intake
  logic         accept;
  logic         req_ok;
  logic [2:0]   cnt_r;
  logic [2:0]   cnt_nxt;
  logic [P2_LVL:0] vld_r;
  flags_t       s0_fl_r;
  logic [9:0]   s0_k_r;
  logic [9:0]   s0_j_r;

  assign accept = start && !busy;
  assign busy   = cnt_r != 3'd0;

  assign req_ok = (in_req_type != cmv_pkg::REQ_NONE)
               && ({1'b0, in_side_index} < n_eff)
               && ((in_req_type != cmv_pkg::REQ_SIDE) || ({1'b0, in_segment_index} < sg_eff));

  // Space items by their vertex count so the emitter is always free on arrival.
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (!req_ok) begin
        cnt_nxt = 3'd0;
      end else if (in_req_type == cmv_pkg::REQ_SIDE) begin
        cnt_nxt = 3'd5;
      end else begin
        cnt_nxt = 3'd2;
      end
    end else if (cnt_r != 3'd0) begin
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      vld_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      vld_r <= {vld_r[P2_LVL-1:0], accept && req_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_fl_r.side <= in_req_type == cmv_pkg::REQ_SIDE;
      s0_fl_r.top  <= in_req_type == cmv_pkg::REQ_TOP;
      s0_k_r       <= in_side_index;
      s0_j_r       <= in_segment_index;
    end
  end

  // ---------------------------------------------------------------- dividers
  // Angle and u come from k*2^17/n; y from j*H/S; v from j*2^16/S.
  logic [10:0]      k1;
  logic [10:0]      j1;
  logic [NUM_W-1:0] num_k, num_k1, num_yt, num_yb, num_vt, num_vb;
  logic [QW-1:0]    q_k, q_k1, q_yt, q_yb, q_vt, q_vb;
  flags_t           d_fl;

  assign k1     = {1'b0, s0_k_r} + 11'd1;
  assign j1     = {1'b0, s0_j_r} + 11'd1;
  assign num_k  = NUM_W'({s0_k_r, 17'd0});
  assign num_k1 = NUM_W'({k1, 17'd0});
  assign num_yt = NUM_W'(j1) * NUM_W'(cyl_height_r);
  assign num_yb = NUM_W'(s0_j_r) * NUM_W'(cyl_height_r);
  assign num_vt = NUM_W'({j1, 16'd0});
  assign num_vb = NUM_W'({s0_j_r, 16'd0});

  cmv_div #(.QW(QW), .DW(DW)) u_div_k  (.clk(clk), .num(num_k),  .den(n_eff),  .quo(q_k));
  cmv_div #(.QW(QW), .DW(DW)) u_div_k1 (.clk(clk), .num(num_k1), .den(n_eff),  .quo(q_k1));
  cmv_div #(.QW(QW), .DW(DW)) u_div_yt (.clk(clk), .num(num_yt), .den(sg_eff), .quo(q_yt));
  cmv_div #(.QW(QW), .DW(DW)) u_div_yb (.clk(clk), .num(num_yb), .den(sg_eff), .quo(q_yb));
  cmv_div #(.QW(QW), .DW(DW)) u_div_vt (.clk(clk), .num(num_vt), .den(sg_eff), .quo(q_vt));
  cmv_div #(.QW(QW), .DW(DW)) u_div_vb (.clk(clk), .num(num_vb), .den(sg_eff), .quo(q_vb));

  cmv_delay #(.W($bits(flags_t)), .DEPTH(DIV_LAT)) u_dly_fl (
    .clk(clk), .d(s0_fl_r), .q(d_fl)
  );

  // ---------------------------------------------------------------- angle stage
  // Round the phase to B bits, split off the quadrant, scale the rest to radians.
  logic [18:0]          sum0, sum1;
  logic [B-1:0]         idx0, idx1;
  logic [RB+30:0]       zp0, zp1;
  logic signed [31:0]   ybot, ytop, yt, yb;
  logic signed [CW-1:0] a_z0_r, a_z1_r;
  pay_t                 a_pay_r;
  pay_t                 c_pay;

  assign sum0 = 19'(q_k[17:0])  + 19'(2 ** (16 - B));
  assign sum1 = 19'(q_k1[17:0]) + 19'(2 ** (16 - B));
  assign idx0 = sum0[17-B +: B];
  assign idx1 = sum1[17-B +: B];
  assign zp0  = (RB+31)'(idx0[RB-1:0]) * (RB+31)'(cmv_pkg::HALF_PI_Q30);
  assign zp1  = (RB+31)'(idx1[RB-1:0]) * (RB+31)'(cmv_pkg::HALF_PI_Q30);

  assign ybot = -$signed({2'b0, cyl_height_r[30:1]});
  assign ytop = ybot + $signed({1'b0, cyl_height_r});
  assign yt   = ybot + $signed({1'b0, q_yt});
  assign yb   = ybot + $signed({1'b0, q_yb});

  always_ff @(posedge clk) begin
    a_z0_r        <= CW'(zp0[RB +: 31]);
    a_z1_r        <= CW'(zp1[RB +: 31]);
    a_pay_r.fl    <= d_fl;
    a_pay_r.quad0 <= idx0[B-1:B-2];
    a_pay_r.quad1 <= idx1[B-1:B-2];
    a_pay_r.u_l   <= q_k[17:1];
    a_pay_r.u_r   <= q_k1[17:1];
    a_pay_r.v_t   <= q_vt[16:0];
    a_pay_r.v_b   <= q_vb[16:0];
    a_pay_r.y_a   <= d_fl.side ? yt : (d_fl.top ? ytop : ybot);
    a_pay_r.y_b   <= yb;
  end

  // ---------------------------------------------------------------- CORDIC
  logic signed [CW-1:0] cx0, cy0, cx1, cy1;

  cmv_cordic u_cordic0 (.clk(clk), .z_in(a_z0_r), .x_out(cx0), .y_out(cy0));
  cmv_cordic u_cordic1 (.clk(clk), .z_in(a_z1_r), .x_out(cx1), .y_out(cy1));

  cmv_delay #(.W($bits(pay_t)), .DEPTH(CORDIC_LAT)) u_dly_pay (
    .clk(clk), .d(a_pay_r), .q(c_pay)
  );

  // ---------------------------------------------------------------- post stages
  cs_t                    p1_cs0_r, p1_cs1_r;
  pay_t                   p1_pay_r;
  logic signed [CW+31:0]  p2_px0_r, p2_pz0_r, p2_px1_r, p2_pz1_r;
  logic signed [17:0]     p2_c0_r, p2_s0_r, p2_c1_r, p2_s1_r;
  pay_t                   p2_pay_r;
  logic signed [31:0]     rad_s;

  assign rad_s = $signed({1'b0, cyl_radius_r});

  // Fold the quadrant back in; caps other than the top and the side wall turn backwards.
  always_ff @(posedge clk) begin
    p1_cs0_r <= quad_map(c_pay.quad0, !c_pay.fl.top, cx0, cy0);
    p1_cs1_r <= quad_map(c_pay.quad1, !c_pay.fl.top, cx1, cy1);
    p1_pay_r <= c_pay;
  end

  always_ff @(posedge clk) begin
    p2_px0_r <= p1_cs0_r.c * rad_s;
    p2_pz0_r <= p1_cs0_r.s * rad_s;
    p2_px1_r <= p1_cs1_r.c * rad_s;
    p2_pz1_r <= p1_cs1_r.s * rad_s;
    p2_c0_r  <= to_q16(p1_cs0_r.c);
    p2_s0_r  <= to_q16(p1_cs0_r.s);
    p2_c1_r  <= to_q16(p1_cs1_r.c);
    p2_s1_r  <= to_q16(p1_cs1_r.s);
    p2_pay_r <= p1_pay_r;
  end

  vset_t set_nxt;

  always_comb begin
    set_nxt.fl   = p2_pay_r.fl;
    set_nxt.x_l  = rim_sat(p2_px0_r);
    set_nxt.z_l  = rim_sat(p2_pz0_r);
    set_nxt.x_r  = rim_sat(p2_px1_r);
    set_nxt.z_r  = rim_sat(p2_pz1_r);
    set_nxt.nx_l = p2_c0_r;
    set_nxt.nz_l = p2_s0_r;
    set_nxt.nx_r = p2_c1_r;
    set_nxt.nz_r = p2_s1_r;
    set_nxt.y_a  = p2_pay_r.y_a;
    set_nxt.y_b  = p2_pay_r.y_b;
    if (p2_pay_r.fl.side) begin
      set_nxt.tu_l = p2_pay_r.u_l;
      set_nxt.tu_r = p2_pay_r.u_r;
      set_nxt.tv_0 = p2_pay_r.v_t;
      set_nxt.tv_1 = p2_pay_r.v_b;
    end else begin
      set_nxt.tu_l = tex_of(p2_c0_r);
      set_nxt.tu_r = tex_of(p2_c1_r);
      set_nxt.tv_0 = tex_of(p2_s0_r);
      set_nxt.tv_1 = tex_of(p2_s1_r);
    end
  end

  // ---------------------------------------------------------------- emitter
  // Hold the finished vertex set and walk its vertices, one per cycle.
  vset_t              hold_r;
  logic               emit_act_r;
  logic [2:0]         emit_idx_r;
  logic               v_last;
  logic signed [31:0] v_px, v_py, v_pz;
  logic signed [17:0] v_nx, v_ny, v_nz;
  logic [16:0]        v_u, v_v;
  logic signed [17:0] cap_ny;

  assign cap_ny = hold_r.fl.top ? 18'sd65536 : -18'sd65536;

  always_comb begin
    v_px = hold_r.x_l;
    v_py = hold_r.y_a;
    v_pz = hold_r.z_l;
    v_nx = hold_r.nx_l;
    v_ny = '0;
    v_nz = hold_r.nz_l;
    v_u  = hold_r.tu_l;
    v_v  = hold_r.tv_0;
    if (hold_r.fl.side) begin
      v_last = emit_idx_r == 3'd5;
      case (emit_idx_r)
        3'd0: ;                                        // left top
        3'd1, 3'd4: begin                              // left bottom
          v_py = hold_r.y_b;
          v_v  = hold_r.tv_1;
        end
        3'd2, 3'd3: begin                              // right top
          v_px = hold_r.x_r;
          v_pz = hold_r.z_r;
          v_nx = hold_r.nx_r;
          v_nz = hold_r.nz_r;
          v_u  = hold_r.tu_r;
        end
        default: begin                                 // right bottom
          v_px = hold_r.x_r;
          v_py = hold_r.y_b;
          v_pz = hold_r.z_r;
          v_nx = hold_r.nx_r;
          v_nz = hold_r.nz_r;
          v_u  = hold_r.tu_r;
          v_v  = hold_r.tv_1;
        end
      endcase
    end else begin
      v_last = emit_idx_r == 3'd2;
      v_nx   = '0;
      v_ny   = cap_ny;
      v_nz   = '0;
      case (emit_idx_r)
        3'd0: begin                                    // centre
          v_px = '0;
          v_pz = '0;
          v_u  = 17'd32768;
          v_v  = 17'd32768;
        end
        3'd1: begin                                    // rim at k+1
          v_px = hold_r.x_r;
          v_pz = hold_r.z_r;
          v_u  = hold_r.tu_r;
          v_v  = hold_r.tv_1;
        end
        default: ;                                     // rim at k
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (vld_r[P2_LVL]) begin
      hold_r <= set_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_act_r      <= 1'b0;
      emit_idx_r      <= '0;
      out_valid       <= 1'b0;
      out_last_vertex <= 1'b0;
    end else begin
      out_valid       <= emit_act_r;
      out_last_vertex <= emit_act_r && v_last;
      if (vld_r[P2_LVL]) begin
        emit_act_r <= 1'b1;
        emit_idx_r <= '0;
      end else if (emit_act_r) begin
        emit_idx_r <= emit_idx_r + 3'd1;
        if (v_last) begin
          emit_act_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_act_r) begin
      out_pos_x  <= v_px;
      out_pos_y  <= v_py;
      out_pos_z  <= v_pz;
      out_norm_x <= v_nx;
      out_norm_y <= v_ny;
      out_norm_z <= v_nz;
      out_tex_u  <= v_u;
      out_tex_v  <= v_v;
    end
  end

endmodule

// File: rtl/cmv_delay.sv
// Fixed-length register delay line for payload that travels beside a long unit.
`timescale 1ns / 1ps

module cmv_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    tap_r[0] <= d;
    for (int i = 1; i < DEPTH; i++) begin
      tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

// File: rtl/cmv_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module cmv_div #(
  parameter int QW = 31,
  parameter int DW = 11
) (
  input  logic             clk,
  input  logic [QW+DW-1:0] num,   // top DW bits must be below den
  input  logic [DW-1:0]    den,
  output logic [QW-1:0]    quo
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW+1];

  always_ff @(posedge clk) begin
    rem_r[0] <= num[QW+DW-1:QW];
    low_r[0] <= num[QW-1:0];
    den_r[0] <= den;
    quo_r[0] <= '0;
  end

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;
    assign trial = {rem_r[g], low_r[g][QW-1]};
    assign ge    = trial >= {1'b0, den_r[g]};

    always_ff @(posedge clk) begin
      quo_r[g+1] <= {quo_r[g][QW-2:0], ge};
    end

    if (g < QW-1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[g+1] <= ge ? DW'(trial - {1'b0, den_r[g]}) : DW'(trial);
        low_r[g+1] <= low_r[g] << 1;
        den_r[g+1] <= den_r[g];
      end
    end
  end

  assign quo = quo_r[QW];

endmodule

// File: rtl/cmv_cordic.sv
// Pipelined rotation-mode CORDIC giving cos and sin in Q2.30, one iteration per stage.
`timescale 1ns / 1ps

module cmv_cordic (
  input  logic                           clk,
  input  logic signed [cmv_pkg::CW-1:0] z_in,
  output logic signed [cmv_pkg::CW-1:0] x_out,
  output logic signed [cmv_pkg::CW-1:0] y_out
);

  localparam int N = cmv_pkg::CORDIC_ITER;

  logic signed [cmv_pkg::CW-1:0] x_r [N+1];
  logic signed [cmv_pkg::CW-1:0] y_r [N+1];
  logic signed [cmv_pkg::CW-1:0] z_r [N];

  always_ff @(posedge clk) begin
    x_r[0] <= cmv_pkg::GAIN_Q30;
    y_r[0] <= '0;
    z_r[0] <= z_in;
  end

  for (genvar g = 0; g < N; g++) begin : g_iter
    logic signed [cmv_pkg::CW-1:0] dx;
    logic signed [cmv_pkg::CW-1:0] dy;
    logic                          pos;
    assign dx  = y_r[g] >>> g;
    assign dy  = x_r[g] >>> g;
    assign pos = !z_r[g][cmv_pkg::CW-1];

    always_ff @(posedge clk) begin
      x_r[g+1] <= pos ? x_r[g] - dx : x_r[g] + dx;
      y_r[g+1] <= pos ? y_r[g] + dy : y_r[g] - dy;
    end

    if (g < N-1) begin : g_angle
      always_ff @(posedge clk) begin
        z_r[g+1] <= pos ? z_r[g] - cmv_pkg::atan_q30(g) : z_r[g] + cmv_pkg::atan_q30(g);
      end
    end
  end

  assign x_out = x_r[N];
  assign y_out = y_r[N];

endmodule

// File: rtl/cmv_checker.sv
// Port-level checks for the cylinder mesh vertex generator and their binding.
`timescale 1ns / 1ps

module cmv_props (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_req_type,
  input logic       out_valid,
  input logic       out_last_vertex
);

  // The last mark only ever rides on a vertex.
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_vertex |-> out_valid)
    else $error("last mark without a vertex");

  // Vertices of one item leave without gaps.
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_vertex |=> out_valid)
    else $error("gap inside a vertex burst");

  // An item of the unused kind does not raise busy.
  a_none_free: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type == cmv_pkg::REQ_NONE |=> !busy)
    else $error("unused request kind raised busy");

  // Reset leaves the block idle and silent.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("activity right after reset");

endmodule

bind cylinder_mesh_vertex_generator cmv_props u_cmv_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .in_req_type(in_req_type),
  .out_valid(out_valid),
  .out_last_vertex(out_last_vertex)
);

// File: bench/cmv_checker.sv
// Checker for the cylinder mesh vertex generator: predicts vertices and compares results.
`timescale 1ns / 1ps

module cmv_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    in_req_type,
  input  logic [9:0]                    in_side_index,
  input  logic [9:0]                    in_segment_index,
  input  logic                          out_valid,
  input  logic signed [31:0]            out_pos_x,
  input  logic signed [31:0]            out_pos_y,
  input  logic signed [31:0]            out_pos_z,
  input  logic signed [17:0]            out_norm_x,
  input  logic signed [17:0]            out_norm_y,
  input  logic signed [17:0]            out_norm_z,
  input  logic [16:0]                   out_tex_u,
  input  logic [16:0]                   out_tex_v,
  input  logic                          out_last_vertex,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [cmv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output int                            fail_count,
  output int                            vertices_pending,
  output int                            vertices_checked
);

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [17:0] nx, ny, nz;
    logic [16:0]        u, v;
    logic               last;
  } vertex_t;

  localparam longint ATAN_TAB [16] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767
  };

  vertex_t     expected_vertices[$];
  logic [30:0] radius, height;
  logic [10:0] sides, segments;

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // cos/sin in Q2.30 of the rim angle, phase rounded to 12 bits per turn
  task automatic rim_trig(input longint k, input longint n, input bit neg,
                          output longint c, output longint s);
    longint idx, rem, x, y, z, dx, dy;
    int q;
    idx = ((k << 12) * 2 + n) / (2 * n);
    idx = idx & 4095;
    q = int'(idx >> 10);
    rem = idx & 1023;
    z = (rem * 1686629713) >> 10;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    case (q)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    if (neg) s = -s;
  endtask

  function automatic longint to_q16(longint v);
    return clampl((v + 8192) >>> 14, -65536, 65536);
  endfunction

  function automatic longint rim_coord(longint v);
    return clampl((v * longint'(radius) + (64'sd1 <<< 29)) >>> 30,
                  -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic vertex_t mk(longint px, py, pz, nx, ny, nz, u, v, bit last);
    vertex_t r;
    r.px = px[31:0]; r.py = py[31:0]; r.pz = pz[31:0];
    r.nx = nx[17:0]; r.ny = ny[17:0]; r.nz = nz[17:0];
    r.u = u[16:0]; r.v = v[16:0]; r.last = last;
    return r;
  endfunction

  // append one vertex to the expected stream
  task automatic queue_vertex(input vertex_t vx);
    expected_vertices = {expected_vertices, vx};
  endtask

  task automatic predict_primitive(input logic [1:0] kind, input longint k, input longint j);
    longint n, sg, ybot, ytop, y, ny, c0, s0, c1, s1, yt, yb;
    n = clampl(sides, 3, 1024);
    sg = clampl(segments, 1, 1024);
    ybot = -longint'(height >> 1);
    ytop = ybot + longint'(height);
    // drop the unused kind and out-of-range indexes: nothing comes out
    if (kind == cmv_pkg::REQ_NONE || k >= n) return;
    if (kind != cmv_pkg::REQ_SIDE) begin
      y = (kind == cmv_pkg::REQ_TOP) ? ytop : ybot;
      ny = (kind == cmv_pkg::REQ_TOP) ? 65536 : -65536;
      rim_trig(k, n, kind != cmv_pkg::REQ_TOP, c0, s0);
      rim_trig(k + 1, n, kind != cmv_pkg::REQ_TOP, c1, s1);
      queue_vertex(mk(0, y, 0, 0, ny, 0, 32768, 32768, 0));
      queue_vertex(mk(rim_coord(c1), y, rim_coord(s1), 0, ny, 0,
        (to_q16(c1) + 65536) >> 1, (to_q16(s1) + 65536) >> 1, 0));
      queue_vertex(mk(rim_coord(c0), y, rim_coord(s0), 0, ny, 0,
        (to_q16(c0) + 65536) >> 1, (to_q16(s0) + 65536) >> 1, 1));
      return;
    end
    if (j >= sg) return;
    rim_trig(k, n, 1, c0, s0);
    rim_trig(k + 1, n, 1, c1, s1);
    yt = ybot + ((j + 1) * longint'(height)) / sg;
    yb = ybot + (j * longint'(height)) / sg;
    queue_vertex(mk(rim_coord(c0), yt, rim_coord(s0), to_q16(c0), 0,
      to_q16(s0), (k << 16) / n, ((j + 1) << 16) / sg, 0));
    queue_vertex(mk(rim_coord(c0), yb, rim_coord(s0), to_q16(c0), 0,
      to_q16(s0), (k << 16) / n, (j << 16) / sg, 0));
    queue_vertex(mk(rim_coord(c1), yt, rim_coord(s1), to_q16(c1), 0,
      to_q16(s1), ((k + 1) << 16) / n, ((j + 1) << 16) / sg, 0));
    queue_vertex(mk(rim_coord(c1), yt, rim_coord(s1), to_q16(c1), 0,
      to_q16(s1), ((k + 1) << 16) / n, ((j + 1) << 16) / sg, 0));
    queue_vertex(mk(rim_coord(c0), yb, rim_coord(s0), to_q16(c0), 0,
      to_q16(s0), (k << 16) / n, (j << 16) / sg, 0));
    queue_vertex(mk(rim_coord(c1), yb, rim_coord(s1), to_q16(c1), 0,
      to_q16(s1), ((k + 1) << 16) / n, (j << 16) / sg, 1));
  endtask

  always @(posedge clk) begin
    vertex_t got, want;
    if (!rst_n) begin
      radius <= 31'd65536;
      height <= 31'd65536;
      sides <= 11'd16;
      segments <= 11'd1;
      expected_vertices.delete();
      fail_count <= 0;
      vertices_checked <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cmv_pkg::CFG_RADIUS:   radius <= cfg_data[30:0];
          cmv_pkg::CFG_HEIGHT:   height <= cfg_data[30:0];
          cmv_pkg::CFG_SIDES:    sides <= cfg_data[10:0];
          cmv_pkg::CFG_SEGMENTS: segments <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (start && !busy)
        predict_primitive(in_req_type, in_side_index, in_segment_index);
      if (out_valid) begin
        got = '{out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z,
                out_tex_u, out_tex_v, out_last_vertex};
        if (expected_vertices.size() == 0) begin
          $display("%0t: unexpected vertex %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_vertices.pop_front();
          vertices_checked <= vertices_checked + 1;
          if (got !== want) begin
            $display("%0t: vertex mismatch, expected %p, actual %p", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    vertices_pending = expected_vertices.size();
  end
endmodule

// File: bench/cylinder_mesh_vertex_generator_test.sv
// Testbench top for the cylinder mesh vertex generator: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module cylinder_mesh_vertex_generator_test;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 80;   // comfortably past the pipeline

  logic        clk, rst_n, start, busy;
  logic [1:0]  in_req_type;
  logic [9:0]  in_side_index, in_segment_index;
  logic        out_valid, out_last_vertex;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [17:0] out_norm_x, out_norm_y, out_norm_z;
  logic [16:0] out_tex_u, out_tex_v;
  logic        cfg_valid, cfg_ready;
  logic [cmv_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  int fail_count, vertices_pending, vertices_checked;
  int items_sent, stall_cycles;
  int eff_sides, eff_segments;
  bit no_idle;

  cylinder_mesh_vertex_generator i_dut (.*);

  cmv_checker i_checker (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Count cycles with no handshake of any kind; give up when the block hangs.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one request; hold it until the block takes it.
  task automatic send_item(input logic [1:0] kind, input int k, input int j);
    bit held;
    if (!no_idle && $urandom_range(0, 99) < 34) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= kind;
    in_side_index <= k[9:0];
    in_segment_index <= j[9:0];
    do begin
      @(negedge clk);
      held = busy;
      @(posedge clk);
    end while (held);
    items_sent++;
  endtask

  task automatic write_reg(input logic [cmv_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    bit ready_seen;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      ready_seen = cfg_ready;
      @(posedge clk);
    end while (!ready_seen);
  endtask

  // Wait out every pending vertex, plus the pipeline for items that give none.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (vertices_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] r, h, s, g);
    wait_idle();
    write_reg(cmv_pkg::CFG_RADIUS, r);
    write_reg(cmv_pkg::CFG_HEIGHT, h);
    write_reg(cmv_pkg::CFG_SIDES, s);
    write_reg(cmv_pkg::CFG_SEGMENTS, g);
    // an unknown index must leave every register alone
    write_reg(cmv_pkg::CFG_IDX_W'($urandom_range(4, 15)), $urandom);
    cfg_valid <= 1'b0;
    @(posedge clk);
    eff_sides = s[10:0] < 3 ? 3 : (s[10:0] > 1024 ? 1024 : s[10:0]);
    eff_segments = g[10:0] < 1 ? 1 : (g[10:0] > 1024 ? 1024 : g[10:0]);
  endtask

  // Extremes of the indexes, every kind, and the requests that give nothing.
  task automatic directed_items();
    send_item(cmv_pkg::REQ_TOP, 0, 0);
    send_item(cmv_pkg::REQ_TOP, eff_sides - 1, 1023);
    send_item(cmv_pkg::REQ_BOTTOM, 0, 0);
    send_item(cmv_pkg::REQ_BOTTOM, eff_sides - 1, 0);
    send_item(cmv_pkg::REQ_SIDE, 0, 0);
    send_item(cmv_pkg::REQ_SIDE, eff_sides - 1, eff_segments - 1);
    send_item(cmv_pkg::REQ_NONE, 0, 0);
    if (eff_sides < 1024) send_item(cmv_pkg::REQ_TOP, 1023, 0);
    if (eff_segments < 1024) send_item(cmv_pkg::REQ_SIDE, 0, 1023);
  endtask

  // Mostly well-formed requests; about one in ten is random noise.
  task automatic random_items(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(2'($urandom_range(0, 3)), $urandom_range(0, 1023),
                  $urandom_range(0, 1023));
      else
        send_item(2'($urandom_range(0, 2)), $urandom_range(0, eff_sides - 1),
                  $urandom_range(0, eff_segments - 1));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = '0;
    in_side_index = '0;
    in_segment_index = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    items_sent = 0;
    no_idle = 0;
    eff_sides = 16;
    eff_segments = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults from reset
    directed_items();
    random_items(45);
    // largest radius and height, fewest sides, most segments
    apply_settings(32'h7FFF_FFFF, 32'hFFFF_FFFF, 3, 1024);
    directed_items();
    random_items(50);
    // zero radius and height, most sides; run this phase with no idling
    no_idle = 1;
    apply_settings(0, 0, 1024, 1);
    directed_items();
    random_items(70);
    no_idle = 0;
    // out-of-range counts saturate low
    apply_settings(1, 1, 0, 0);
    directed_items();
    random_items(40);
    // out-of-range counts saturate high
    apply_settings($urandom, $urandom, 32'hFFFF_F7FF | 32'h7FF, 2047);
    directed_items();
    random_items(50);
    for (int p = 0; p < 3; p++) begin
      apply_settings($urandom, $urandom_range(0, 32'h0040_0000),
                     $urandom_range(3, 1024), $urandom_range(1, 64));
      random_items(45);
    end

    wait_idle();
    $display("Sent %0d requests over eight register settings; %0d vertices checked.",
             items_sent, vertices_checked);
    if (fail_count == 0 && vertices_pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
